@@ src/tti_pkg.sv @@
// types and constants shared by the thermistor table interpolator
`default_nettype none

package tti_pkg;

    localparam int ADC_W  = 12;
    localparam int TEMP_W = 15;
    localparam int SPAN_W = 8;
    localparam int RND_W  = 9;

    typedef logic [ADC_W-1:0]         t_adc;
    typedef logic signed [TEMP_W-1:0] t_temp;
    typedef logic [SPAN_W-1:0]        t_span;

    localparam int ROM_SIZE  = 34;
    localparam int TEMP_LOW  = -4000;
    localparam int TEMP_STEP = 500;
    localparam int TEMP_HIGH = TEMP_LOW + TEMP_STEP * (ROM_SIZE - 1);

    localparam t_adc ADC_POINTS [ROM_SIZE] = '{
        12'd156,  12'd211,  12'd279,  12'd363,  12'd464,  12'd585,  12'd724,
        12'd881,  12'd1055, 12'd1242, 12'd1439, 12'd1642, 12'd1847, 12'd2048,
        12'd2243, 12'd2428, 12'd2601, 12'd2762, 12'd2908, 12'd3040, 12'd3159,
        12'd3265, 12'd3359, 12'd3443, 12'd3516, 12'd3581, 12'd3638, 12'd3687,
        12'd3731, 12'd3770, 12'd3804, 12'd3834, 12'd3860, 12'd3884
    };

endpackage

`default_nettype wire

@@ src/tti_if.sv @@
// valid/ready channel interfaces for samples and temperatures
`default_nettype none

interface tti_sample_if;
    import tti_pkg::*;
    logic valid;
    logic ready;
    t_adc adc_sample;
    modport source(output valid, output adc_sample, input ready);
    modport sink(input valid, input adc_sample, output ready);
endinterface

interface tti_temp_if;
    import tti_pkg::*;
    logic  valid;
    logic  ready;
    t_temp temperature;
    modport source(output valid, output temperature, input ready);
    modport sink(input valid, input temperature, output ready);
endinterface

`default_nettype wire

@@ src/thermistor_table_interpolator.sv @@
// Thermistor ADC to temperature converter, 0.01 degC steps, piecewise linear over a fixed table.
// One sample is taken every clock cycle while the output is not stalled. It passes through an
// eight-stage pipeline: breakpoint compare, segment encode, table fetch, reciprocal multiply,
// check multiply, quotient correction, scaling with rounding, and the output register. A stall
// on the output only holds stages that are full, so empty stages keep taking new samples.
// Samples below the first breakpoint give -40.00 degC; samples at or above the last used
// breakpoint give that point's temperature. TABLE_POINTS selects how many of the 34 stored
// points are used, FRACTION_BITS the precision of the interpolation fraction.
`default_nettype none

module thermistor_table_interpolator #(
    parameter int TABLE_POINTS  = 34,
    parameter int FRACTION_BITS = 24
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    tti_sample_if.sink    i_sample,
    tti_temp_if.source    o_temp
);
    import tti_pkg::*;

    localparam int NP = (TABLE_POINTS > ROM_SIZE) ? ROM_SIZE : TABLE_POINTS;
    localparam int IW = (NP > 1) ? $clog2(NP) : 1;
    localparam int F  = FRACTION_BITS;
    localparam int RW = F + SPAN_W;
    localparam int PW = RW + SPAN_W;
    localparam int QW = F + 2;
    localparam int CW = QW + SPAN_W;
    localparam int FW = F + 1;
    localparam int MW = F + 10;
    localparam int NS = 8;
    localparam logic [MW-1:0] HALF = MW'(1) << (F - 1);

    // constant segment tables
    t_adc          w_bp    [NP];
    t_span         w_span  [NP];
    logic [RW-1:0] w_recip [NP];
    t_temp         w_tpt   [NP];

    for (genvar g = 0; g < NP; g++) begin : g_tab
        localparam int GP = (g == 0) ? 0 : g - 1;
        localparam longint SPAN = (g == 0) ? 1 :
            longint'(ADC_POINTS[g]) - longint'(ADC_POINTS[GP]);
        localparam longint RCP = ((64'sd1 <<< (F + SPAN_W)) + SPAN - 1) / SPAN;
        assign w_bp[g]    = ADC_POINTS[g];
        assign w_span[g]  = SPAN_W'(SPAN);
        assign w_recip[g] = RW'(RCP);
        assign w_tpt[g]   = TEMP_W'(TEMP_LOW + TEMP_STEP * g);
    end

    // pipeline control
    logic [NS-1:0] r_vld;
    logic [NS-1:0] w_en;

    always_comb begin
        w_en[NS-1] = !r_vld[NS-1] || o_temp.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign i_sample.ready = w_en[0];

    // stage registers
    t_adc          r1_smp;
    logic [NP-1:0] r1_ge;
    t_adc          r2_smp;
    logic [IW-1:0] r2_idx;
    logic          r2_sat;
    logic [IW-1:0] r3_idx, r4_idx, r5_idx, r6_idx, r7_idx;
    logic          r3_sat, r4_sat, r5_sat, r6_sat, r7_sat;
    t_span         r3_dist, r4_dist, r5_dist;
    t_span         r3_span, r4_span;
    logic [RW-1:0] r3_recip;
    logic [QW-1:0] r4_q0, r5_q0;
    logic [CW-1:0] r5_chk;
    logic [FW-1:0] r6_frac;
    logic [RND_W-1:0] r7_rnd;
    t_temp         r_temp;

    logic [NP-1:0]    n_ge;
    logic [IW-1:0]    n_idx;
    logic             n_sat;
    logic [PW-1:0]    n_prod;
    logic [CW-1:0]    n_chk;
    logic [CW-1:0]    n_num;
    logic [FW-1:0]    n_frac;
    logic [MW-1:0]    n_scaled;
    t_temp            n_temp;

    always_comb begin
        for (int k = 0; k < NP; k++) begin
            n_ge[k] = (i_sample.adc_sample >= w_bp[k]);
        end
    end

    always_comb begin
        n_idx = IW'(NP - 1);
        for (int k = NP - 1; k >= 1; k--) begin
            if (!r1_ge[k]) begin
                n_idx = IW'(k);
            end
        end
        n_sat = !r1_ge[0] || r1_ge[NP-1];
        if (!r1_ge[0]) begin
            n_idx = '0;
        end
    end

    assign n_prod   = PW'(r3_dist) * PW'(r3_recip);
    assign n_chk    = CW'(r4_q0) * CW'(r4_span);
    assign n_num    = CW'({r5_dist, F'(0)});
    assign n_frac   = (r5_chk > n_num) ? FW'(r5_q0 - QW'(1)) : FW'(r5_q0);
    assign n_scaled = MW'(r6_frac) * MW'(TEMP_STEP) + HALF;
    assign n_temp   = r7_sat ? w_tpt[r7_idx]
                             : w_tpt[r7_idx] - $signed(TEMP_W'(r7_rnd));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= (k == 0) ? i_sample.valid : r_vld[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_smp <= i_sample.adc_sample;
            r1_ge  <= n_ge;
        end
        if (w_en[1]) begin
            r2_smp <= r1_smp;
            r2_idx <= n_idx;
            r2_sat <= n_sat;
        end
        if (w_en[2]) begin
            r3_idx   <= r2_idx;
            r3_sat   <= r2_sat;
            r3_dist  <= SPAN_W'(w_bp[r2_idx] - r2_smp);
            r3_span  <= w_span[r2_idx];
            r3_recip <= w_recip[r2_idx];
        end
        if (w_en[3]) begin
            r4_idx  <= r3_idx;
            r4_sat  <= r3_sat;
            r4_dist <= r3_dist;
            r4_span <= r3_span;
            r4_q0   <= n_prod[SPAN_W +: QW];
        end
        if (w_en[4]) begin
            r5_idx  <= r4_idx;
            r5_sat  <= r4_sat;
            r5_dist <= r4_dist;
            r5_q0   <= r4_q0;
            r5_chk  <= n_chk;
        end
        if (w_en[5]) begin
            r6_idx  <= r5_idx;
            r6_sat  <= r5_sat;
            r6_frac <= n_frac;
        end
        if (w_en[6]) begin
            r7_idx <= r6_idx;
            r7_sat <= r6_sat;
            r7_rnd <= n_scaled[F +: RND_W];
        end
        if (w_en[7]) begin
            r_temp <= n_temp;
        end
    end

    assign o_temp.valid       = r_vld[NS-1];
    assign o_temp.temperature = r_temp;

    // checks
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_temp.valid |-> ($signed(o_temp.temperature) >= $signed(TEMP_W'(TEMP_LOW))
                       && $signed(o_temp.temperature) <= $signed(TEMP_W'(TEMP_HIGH))))
        else $error("temperature out of range");

    a_seg_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && !r3_sat) |-> (r3_idx != '0 && r3_dist != '0 && r3_dist <= r3_span))
        else $error("bad segment selected");

    a_frac_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[5] && !r6_sat) |-> (r6_frac <= (FW'(1) << F)))
        else $error("interpolation fraction above one");

    a_rnd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[6] && !r7_sat) |-> (r7_rnd <= RND_W'(TEMP_STEP)))
        else $error("interpolated step above one table step");

endmodule

`default_nettype wire
